// ----- rtl/bresenham_line_rasterizer_defines.svh -----
// assertion macros for the line rasterizer
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`ifndef SYNTH
// checked property, masked while reset is asserted
`define BLR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("blr check failed");
// checked property, also evaluated during reset
`define BLR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("blr check failed");
`else
`define BLR_ASSERT(lbl, clk, rst_n, prop)
`define BLR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/blr_pkg.sv -----
// shared types and constants for the line rasterizer
// no dependencies
`default_nettype none

package blr_pkg;

    localparam int COLOR_BITS = 32;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    // control from the input stage into the walker core
    typedef struct packed {
        logic fire;
        logic is_step;
    } t_core_ctl;

endpackage

`default_nettype wire

// ----- rtl/blr_cmd_if.sv -----
// request channel of the line rasterizer: command, endpoints and color
// depends on blr_pkg for the color width
`default_nettype none

interface blr_cmd_if #(
    parameter int COORD_BITS = 10
);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [COORD_BITS-1:0]        x_start;
    logic [COORD_BITS-1:0]        y_start;
    logic [COORD_BITS-1:0]        x_end;
    logic [COORD_BITS-1:0]        y_end;
    logic [blr_pkg::COLOR_BITS-1:0] line_color;

    modport source (
        output valid, command, x_start, y_start, x_end, y_end, line_color,
        input  ready
    );
    modport sink (
        input  valid, command, x_start, y_start, x_end, y_end, line_color,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/blr_pix_if.sv -----
// pixel channel of the line rasterizer
// depends on blr_pkg for the color width
`default_nettype none

interface blr_pix_if #(
    parameter int COORD_BITS = 10
);
    logic                           valid;
    logic                           ready;
    logic [COORD_BITS-1:0]          pixel_x;
    logic [COORD_BITS-1:0]          pixel_y;
    logic [blr_pkg::COLOR_BITS-1:0] pixel_color;
    logic                           last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/blr_core.sv -----
// line walker: octant setup on start, one bresenham step per step request
// depends on blr_pkg and the assertion macros header
`default_nettype none
`include "bresenham_line_rasterizer_defines.svh"

module blr_core #(
    parameter int COORD_BITS = 10
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  blr_pkg::t_core_ctl        i_ctl,
    input  wire  [COORD_BITS-1:0]           i_x_start,
    input  wire  [COORD_BITS-1:0]           i_y_start,
    input  wire  [COORD_BITS-1:0]           i_x_end,
    input  wire  [COORD_BITS-1:0]           i_y_end,
    input  wire  [blr_pkg::COLOR_BITS-1:0]  i_color,
    output logic                            o_pix_valid,
    output logic [COORD_BITS-1:0]           o_pix_x,
    output logic [COORD_BITS-1:0]           o_pix_y,
    output logic [blr_pkg::COLOR_BITS-1:0]  o_pix_color,
    output logic                            o_last
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic [COORD_BITS-1:0]          r_major, n_major;
    logic [COORD_BITS-1:0]          r_minor, n_minor;
    logic [COORD_BITS-1:0]          r_bound, n_bound;
    logic [DW-1:0]                  r_dmaj, n_dmaj;
    logic [DW-1:0]                  r_dmin, n_dmin;
    logic signed [EW-1:0]           r_err, n_err;
    logic                           r_dir, n_dir;
    logic                           r_xmaj, n_xmaj;
    logic [blr_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic                           r_active, n_active;

    // setup terms
    logic [COORD_BITS-1:0] adx, ady;
    logic                  x_major;
    logic [COORD_BITS-1:0] ma, mb, na, nb;
    logic                  swap;

    // step terms
    logic [DW-1:0]         major_inc;
    logic                  last;
    logic signed [EW-1:0]  err_sum;
    logic signed [EW:0]    err_twice;
    logic                  minor_move;
    logic                  step_go;

    always_comb begin
        adx     = (i_x_end > i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
        ady     = (i_y_end > i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
        x_major = (adx >= ady);
        ma      = x_major ? i_x_start : i_y_start;
        mb      = x_major ? i_x_end   : i_y_end;
        na      = x_major ? i_y_start : i_x_start;
        nb      = x_major ? i_y_end   : i_x_end;
        swap    = (ma > mb);

        major_inc  = {1'b0, r_major} + DW'(1);
        last       = (major_inc == {1'b0, r_bound});
        err_sum    = r_err + $signed({2'b00, r_dmin});
        err_twice  = {err_sum, 1'b0};
        minor_move = (err_twice >= $signed({3'b000, r_dmaj}));
        step_go    = i_ctl.fire && i_ctl.is_step && r_active;

        n_major  = r_major;
        n_minor  = r_minor;
        n_bound  = r_bound;
        n_dmaj   = r_dmaj;
        n_dmin   = r_dmin;
        n_err    = r_err;
        n_dir    = r_dir;
        n_xmaj   = r_xmaj;
        n_color  = r_color;
        n_active = r_active;

        if (i_ctl.fire && !i_ctl.is_step) begin
            n_xmaj   = x_major;
            n_dmaj   = {1'b0, (x_major ? adx : ady)};
            n_dmin   = {1'b0, (x_major ? ady : adx)};
            n_major  = swap ? mb : ma;
            n_bound  = swap ? ma : mb;
            n_minor  = swap ? nb : na;
            // minor decreases when the far end lies below the near end
            n_dir    = swap ? (na < nb) : (nb < na);
            n_err    = '0;
            n_color  = i_color;
            n_active = (adx != '0) || (ady != '0);
        end else if (step_go) begin
            n_major = major_inc[COORD_BITS-1:0];
            if (minor_move) begin
                n_err   = err_sum - $signed({2'b00, r_dmaj});
                n_minor = r_dir ? (r_minor - COORD_BITS'(1)) : (r_minor + COORD_BITS'(1));
            end else begin
                n_err = err_sum;
            end
            if (last) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major  <= '0;
            r_minor  <= '0;
            r_bound  <= '0;
            r_dmaj   <= '0;
            r_dmin   <= '0;
            r_err    <= '0;
            r_dir    <= 1'b0;
            r_xmaj   <= 1'b0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else begin
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_bound  <= n_bound;
            r_dmaj   <= n_dmaj;
            r_dmin   <= n_dmin;
            r_err    <= n_err;
            r_dir    <= n_dir;
            r_xmaj   <= n_xmaj;
            r_color  <= n_color;
            r_active <= n_active;
        end
    end

    assign o_pix_valid = step_go;
    assign o_pix_x     = r_xmaj ? r_major : r_minor;
    assign o_pix_y     = r_xmaj ? r_minor : r_major;
    assign o_pix_color = r_color;
    assign o_last      = last;

    // error term stays below half the major span while a line is running
    logic err_in_range;
    assign err_in_range = ($signed({r_err, 1'b0}) < $signed({3'b000, r_dmaj}));

    `BLR_ASSERT(a_err_bound, i_clk, i_rst_n, r_active |-> err_in_range)
    `BLR_ASSERT(a_last_ends_line, i_clk, i_rst_n, (step_go && last) |=> !r_active)
    `BLR_ASSERT(a_no_zero_span, i_clk, i_rst_n, r_active |-> (r_dmaj != '0))

endmodule

`default_nettype wire

// ----- rtl/bresenham_line_rasterizer.sv -----
// bresenham line rasterizer top: request register, walker core, pixel register
// depends on blr_pkg, blr_cmd_if, blr_pix_if, blr_core and the macros header
//
// usage:
//   i_cmd carries requests. a start request (command 0) loads both endpoints
//   and a color and produces no pixel. each step request (command 1) produces
//   one pixel on o_pix, walking the major axis from the lower end toward the
//   far end, which itself is not drawn; last_pixel marks the final one. a step
//   with no line running, or a start with equal endpoints, produces nothing.
//   a start while a line is running drops that line.
//   path: each request is captured in the request register when accepted, and
//   its pixel in the pixel register when that register can take a result.
//   throughput: one request per cycle while o_pix is not held off; each step
//   takes one add and compare of the error term, so steps run back to back.
//   stall: when o_pix is held off the pixel register keeps its pixel and the
//   request register fills; i_cmd.ready drops only once both are occupied.
//   reset (i_rst_n low, synchronous) empties both registers and leaves the
//   walker idle with no line loaded.
`default_nettype none
`include "bresenham_line_rasterizer_defines.svh"

module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    blr_cmd_if.sink     i_cmd,
    blr_pix_if.source   o_pix
);

    logic                           r_in_valid;
    logic                           r_in_cmd;
    logic [COORD_BITS-1:0]          r_in_xs;
    logic [COORD_BITS-1:0]          r_in_ys;
    logic [COORD_BITS-1:0]          r_in_xe;
    logic [COORD_BITS-1:0]          r_in_ye;
    logic [blr_pkg::COLOR_BITS-1:0] r_in_color;

    logic                           r_out_valid;
    logic [COORD_BITS-1:0]          r_out_x;
    logic [COORD_BITS-1:0]          r_out_y;
    logic [blr_pkg::COLOR_BITS-1:0] r_out_color;
    logic                           r_out_last;

    logic                           advance;
    logic                           in_take;
    blr_pkg::t_core_ctl             ctl;

    logic                           core_valid;
    logic [COORD_BITS-1:0]          core_x;
    logic [COORD_BITS-1:0]          core_y;
    logic [blr_pkg::COLOR_BITS-1:0] core_color;
    logic                           core_last;

    // the held request moves on whenever the pixel register can take a result
    assign advance      = !r_out_valid || o_pix.ready;
    assign ctl.fire     = r_in_valid && advance;
    assign ctl.is_step  = (r_in_cmd == blr_pkg::CMD_STEP);
    assign i_cmd.ready  = !r_in_valid || advance;
    assign in_take      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (ctl.fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd   <= i_cmd.command;
            r_in_xs    <= i_cmd.x_start;
            r_in_ys    <= i_cmd.y_start;
            r_in_xe    <= i_cmd.x_end;
            r_in_ye    <= i_cmd.y_end;
            r_in_color <= i_cmd.line_color;
        end
    end

    blr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_x_start   (r_in_xs),
        .i_y_start   (r_in_ys),
        .i_x_end     (r_in_xe),
        .i_y_end     (r_in_ye),
        .i_color     (r_in_color),
        .o_pix_valid (core_valid),
        .o_pix_x     (core_x),
        .o_pix_y     (core_y),
        .o_pix_color (core_color),
        .o_last      (core_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_valid) begin
            r_out_x     <= core_x;
            r_out_y     <= core_y;
            r_out_color <= core_color;
            r_out_last  <= core_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.pixel_color = r_out_color;
    assign o_pix.last_pixel  = r_out_last;

    `BLR_ASSERT(a_held_request_stays, i_clk, i_rst_n,
        (r_in_valid && !advance) |=> r_in_valid)
    `BLR_ASSERT(a_pixel_only_on_step, i_clk, i_rst_n,
        core_valid |-> (ctl.fire && ctl.is_step))
    `BLR_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> (!r_in_valid && !r_out_valid))

endmodule

`default_nettype wire
